// ===== src/svpwm_pkg.sv =====
// Shared constants for the min/max space-vector PWM modulator.
// No dependencies; imported by the top level.
package svpwm_pkg;

   localparam int P_W = 35;

   localparam logic [1:0] REG_FULL_COUNT = 2'd0;
   localparam logic [1:0] REG_MIN_PULSE  = 2'd1;
   localparam logic [1:0] REG_CLEAN_ZONE = 2'd2;
   localparam logic [1:0] REG_SPAN_LIMIT = 2'd3;

   localparam logic [15:0] FULL_COUNT_RESET = 16'd4096;
   localparam logic [15:0] MIN_PULSE_RESET  = 16'd8;
   localparam logic [15:0] CLEAN_ZONE_RESET = 16'd0;
   localparam logic [16:0] SPAN_LIMIT_RESET = 17'd32768;

   localparam logic signed [16:0] SQRT3_HALF_Q16 = 17'sd56756;
   localparam logic signed [16:0] INV_SQRT3_Q16  = 17'sd37837;

endpackage

// ===== src/svpwm_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Carries a valid bit and a sideband word alongside; no package dependencies.
module svpwm_div #(
   parameter int NW = 52,
   parameter int DW = 19,
   parameter int QW = 34,
   parameter int SW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QW-1:0] out_quo,
   output logic [SW-1:0] out_side
);

   localparam int RW = DW + 1;

   logic [RW-1:0] rem_ff  [QW];
   logic [QW-1:0] work_ff [QW];
   logic [DW-1:0] den_ff  [QW];
   logic [SW-1:0] side_ff [QW];
   logic          valid_ff [QW];

   for (genvar g = 0; g < QW; g++) begin : g_stage
      logic [RW-1:0] rem_src;
      logic [QW-1:0] work_src;
      logic [DW-1:0] den_src;
      logic [SW-1:0] side_src;
      logic          valid_src;
      logic [RW-1:0] trial;
      logic          take;
      logic [RW-1:0] rem_in;
      logic [QW-1:0] work_in;

      if (g == 0) begin : g_first
         assign rem_src   = RW'(in_num >> QW);
         assign work_src  = in_num[QW-1:0];
         assign den_src   = in_den;
         assign side_src  = in_side;
         assign valid_src = in_valid;
      end else begin : g_next
         assign rem_src   = rem_ff[g-1];
         assign work_src  = work_ff[g-1];
         assign den_src   = den_ff[g-1];
         assign side_src  = side_ff[g-1];
         assign valid_src = valid_ff[g-1];
      end

      assign trial   = {rem_src[RW-2:0], work_src[QW-1]};
      assign take    = trial >= {1'b0, den_src};
      assign rem_in  = take ? trial - {1'b0, den_src} : trial;
      assign work_in = {work_src[QW-2:0], take};

      always_ff @(posedge clock) begin
         rem_ff[g]   <= rem_in;
         work_ff[g]  <= work_in;
         den_ff[g]   <= den_src;
         side_ff[g]  <= side_src;
         valid_ff[g] <= reset ? 1'b0 : valid_src;
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quo   = work_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

// ===== src/minmax_space_vector_pwm.sv =====
// Path: stages 1 to 3, span divider, M1 to M3, A1 to A4, voltage dividers, O1, O2.
// Throughput: one word per cycle; busy stays low, the pipeline takes a word every cycle.
// Depth is set by the 24-stage span divider and the 34-stage voltage dividers.
// Reset is synchronous and active high; it clears the valid bits and loads
// the register defaults. The receiver cannot stall the block.
module minmax_space_vector_pwm
   import svpwm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [16:0] req_volt_alpha,
   input  logic signed [16:0] req_volt_beta,
   input  logic signed [15:0] req_rotor_cos,
   input  logic signed [15:0] req_rotor_sin,
   input  logic [15:0]        req_bus_voltage,
   output logic               rsp_strobe,
   output logic [15:0]        rsp_duty_a,
   output logic [15:0]        rsp_duty_b,
   output logic [15:0]        rsp_duty_c,
   output logic signed [15:0] rsp_applied_alpha,
   output logic signed [15:0] rsp_applied_beta,
   output logic signed [15:0] rsp_applied_direct,
   output logic signed [15:0] rsp_applied_quadrature,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   function automatic logic [15:0] sat16(input logic signed [20:0] v);
      if (v > 21'sd32767) return 16'h7fff;
      if (v < -21'sd32768) return 16'h8000;
      return v[15:0];
   endfunction

   // Configuration registers.
   logic [15:0] full_ff, minp_ff, clean_ff;
   logic [16:0] limit_ff;
   logic [1:0]  csr_index;
   logic        csr_write;

   assign pready    = 1'b1;
   assign busy      = 1'b0;
   assign csr_index = paddr[3:2];
   assign csr_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff  <= FULL_COUNT_RESET;
         minp_ff  <= MIN_PULSE_RESET;
         clean_ff <= CLEAN_ZONE_RESET;
         limit_ff <= SPAN_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_FULL_COUNT: full_ff  <= pwdata[15:0];
            REG_MIN_PULSE:  minp_ff  <= pwdata[15:0];
            REG_CLEAN_ZONE: clean_ff <= pwdata[15:0];
            REG_SPAN_LIMIT: limit_ff <= pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_FULL_COUNT: prdata = {16'd0, full_ff};
         REG_MIN_PULSE:  prdata = {16'd0, minp_ff};
         REG_CLEAN_ZONE: prdata = {16'd0, clean_ff};
         REG_SPAN_LIMIT: prdata = {15'd0, limit_ff};
         default:        prdata = 32'd0;
      endcase
   end

   // Stage 1: phase projection.
   logic signed [P_W-1:0] ph_a_in, ah_in, mb_in;
   logic signed [P_W-1:0] p0_ff, p1_ff, p2_ff;
   logic signed [15:0]    cs1_ff, sn1_ff;
   logic [15:0]           bus1_ff;
   logic                  v1_ff;

   assign ph_a_in = {{2{req_volt_alpha[16]}}, req_volt_alpha, 16'd0};
   assign ah_in   = {{3{req_volt_alpha[16]}}, req_volt_alpha, 15'd0};
   assign mb_in   = P_W'(req_volt_beta) * P_W'(SQRT3_HALF_Q16);

   always_ff @(posedge clock) begin
      p0_ff   <= ph_a_in;
      p1_ff   <= mb_in - ah_in;
      p2_ff   <= -ah_in - mb_in;
      cs1_ff  <= req_rotor_cos;
      sn1_ff  <= req_rotor_sin;
      bus1_ff <= req_bus_voltage;
   end

   // Stage 2: lowest and highest phase.
   logic signed [P_W-1:0] lo_in, hi_in, lo_ff, hi_ff;
   logic signed [P_W-1:0] p0b_ff, p1b_ff, p2b_ff;
   logic signed [15:0]    cs2_ff, sn2_ff;
   logic [15:0]           bus2_ff;
   logic                  v2_ff;

   always_comb begin
      lo_in = p0_ff;
      hi_in = p0_ff;
      if (p1_ff < lo_in) lo_in = p1_ff;
      if (p1_ff > hi_in) hi_in = p1_ff;
      if (p2_ff < lo_in) lo_in = p2_ff;
      if (p2_ff > hi_in) hi_in = p2_ff;
   end

   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      p0b_ff  <= p0_ff;
      p1b_ff  <= p1_ff;
      p2b_ff  <= p2_ff;
      cs2_ff  <= cs1_ff;
      sn2_ff  <= sn1_ff;
      bus2_ff <= bus1_ff;
   end

   // Stage 3: shift to ground, span and limit check.
   logic [P_W-1:0] span_in;
   logic [P_W-1:0] s0_ff, s1_ff, s2_ff, span_ff;
   logic           over_ff;
   logic signed [15:0] cs3_ff, sn3_ff;
   logic [15:0]    bus3_ff;
   logic           v3_ff;

   assign span_in = $unsigned(hi_ff - lo_ff);

   always_ff @(posedge clock) begin
      s0_ff   <= $unsigned(p0b_ff - lo_ff);
      s1_ff   <= $unsigned(p1b_ff - lo_ff);
      s2_ff   <= $unsigned(p2b_ff - lo_ff);
      span_ff <= span_in;
      over_ff <= span_in > {2'b00, limit_ff, 16'd0};
      cs3_ff  <= cs2_ff;
      sn3_ff  <= sn2_ff;
      bus3_ff <= bus2_ff;
   end

   // Scale ratio divider.
   localparam int RSW = 1 + 3 * P_W + 48;
   logic           rv_out;
   logic [23:0]    ratio_out;
   logic [RSW-1:0] rside_out;

   svpwm_div #(.NW(57), .DW(P_W), .QW(24), .SW(RSW)) u_ratio_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v3_ff),
      .in_num   ({limit_ff, 40'd0}),
      .in_den   (span_ff),
      .in_side  ({over_ff, s0_ff, s1_ff, s2_ff, cs3_ff, sn3_ff, bus3_ff}),
      .out_valid(rv_out),
      .out_quo  (ratio_out),
      .out_side (rside_out)
   );

   logic           r_over;
   logic [P_W-1:0] r_s0, r_s1, r_s2;
   logic [15:0]    r_cs, r_sn, r_bus;
   logic [24:0]    ratio_eff;

   assign {r_over, r_s0, r_s1, r_s2, r_cs, r_sn, r_bus} = rside_out;
   assign ratio_eff = r_over ? {1'b0, ratio_out} : 25'h100_0000;

   // M1: scale.
   logic [59:0] pr0_ff, pr1_ff, pr2_ff;
   logic signed [15:0] csm1_ff, snm1_ff, csm2_ff, snm2_ff, csm3_ff, snm3_ff;
   logic [15:0] busm1_ff, busm2_ff, busm3_ff;
   logic        vm1_ff, vm2_ff, vm3_ff;

   always_ff @(posedge clock) begin
      pr0_ff   <= 60'(r_s0) * 60'(ratio_eff);
      pr1_ff   <= 60'(r_s1) * 60'(ratio_eff);
      pr2_ff   <= 60'(r_s2) * 60'(ratio_eff);
      csm1_ff  <= r_cs;
      snm1_ff  <= r_sn;
      busm1_ff <= r_bus;
   end

   // M2: counts times period.
   logic [50:0] cp0_ff, cp1_ff, cp2_ff;

   always_ff @(posedge clock) begin
      cp0_ff   <= 51'(full_ff) * 51'(pr0_ff[58:24]);
      cp1_ff   <= 51'(full_ff) * 51'(pr1_ff[58:24]);
      cp2_ff   <= 51'(full_ff) * 51'(pr2_ff[58:24]);
      csm2_ff  <= csm1_ff;
      snm2_ff  <= snm1_ff;
      busm2_ff <= busm1_ff;
   end

   // M3: rounding and pulse rules.
   logic signed [17:0] guard_w;
   logic [51:0] rs0_w, rs1_w, rs2_w;
   logic [15:0] d0_in, d1_in, d2_in, d0_ff, d1_ff, d2_ff;

   function automatic logic [15:0] to_duty(input logic [20:0] x, input logic [15:0] full,
                                           input logic [15:0] minp,
                                           input logic signed [17:0] guard);
      if (x < {5'd0, minp}) return 16'd0;
      if (guard[17] || (x > {3'd0, guard})) return full;
      return x[15:0];
   endfunction

   assign guard_w = $signed({2'b00, full_ff}) - $signed({2'b00, minp_ff})
                    - $signed({2'b00, clean_ff});
   assign rs0_w   = {1'b0, cp0_ff} + 52'h4000_0000;
   assign rs1_w   = {1'b0, cp1_ff} + 52'h4000_0000;
   assign rs2_w   = {1'b0, cp2_ff} + 52'h4000_0000;
   assign d0_in   = to_duty(rs0_w[51:31], full_ff, minp_ff, guard_w);
   assign d1_in   = to_duty(rs1_w[51:31], full_ff, minp_ff, guard_w);
   assign d2_in   = to_duty(rs2_w[51:31], full_ff, minp_ff, guard_w);

   always_ff @(posedge clock) begin
      d0_ff    <= d0_in;
      d1_ff    <= d1_in;
      d2_ff    <= d2_in;
      csm3_ff  <= csm2_ff;
      snm3_ff  <= snm2_ff;
      busm3_ff <= busm2_ff;
   end

   // A1: phase differences.
   logic signed [18:0] ea_ff;
   logic signed [16:0] eb_ff;
   logic [15:0] da1_ff, db1_ff, dc1_ff, da2_ff, db2_ff, dc2_ff, da3_ff, db3_ff, dc3_ff;
   logic [15:0] da4_ff, db4_ff, dc4_ff;
   logic signed [15:0] csa1_ff, sna1_ff, csa2_ff, sna2_ff, csa3_ff, sna3_ff;
   logic signed [15:0] csa4_ff, sna4_ff;
   logic [15:0] busa1_ff;
   logic        va1_ff, va2_ff, va3_ff, va4_ff;

   always_ff @(posedge clock) begin
      ea_ff    <= $signed({2'b00, d0_ff, 1'b0}) - $signed({3'b000, d1_ff})
                  - $signed({3'b000, d2_ff});
      eb_ff    <= $signed({1'b0, d1_ff}) - $signed({1'b0, d2_ff});
      da1_ff   <= d0_ff;
      db1_ff   <= d1_ff;
      dc1_ff   <= d2_ff;
      csa1_ff  <= csm3_ff;
      sna1_ff  <= snm3_ff;
      busa1_ff <= busm3_ff;
   end

   // A2: times bus voltage.
   logic signed [35:0] na_ff, na3_ff;
   logic signed [33:0] nb_ff;

   always_ff @(posedge clock) begin
      na_ff   <= 36'(ea_ff) * 36'($signed({1'b0, busa1_ff}));
      nb_ff   <= 34'(eb_ff) * 34'($signed({1'b0, busa1_ff}));
      da2_ff  <= da1_ff;
      db2_ff  <= db1_ff;
      dc2_ff  <= dc1_ff;
      csa2_ff <= csa1_ff;
      sna2_ff <= sna1_ff;
   end

   // A3: beta gain.
   logic signed [49:0] nb2_ff;

   always_ff @(posedge clock) begin
      nb2_ff  <= 50'(nb_ff) * 50'(INV_SQRT3_Q16);
      na3_ff  <= na_ff;
      da3_ff  <= da2_ff;
      db3_ff  <= db2_ff;
      dc3_ff  <= dc2_ff;
      csa3_ff <= csa2_ff;
      sna3_ff <= sna2_ff;
   end

   // A4: operands for rounded signed division.
   logic signed [51:0] nsa_w, mag_a_w;
   logic signed [50:0] nsb_w, mag_b_w;
   logic [18:0] dena_w;
   logic [16:0] denb_w;
   logic [51:0] numa_ff;
   logic [50:0] numb_ff;
   logic [18:0] dena_ff;
   logic [16:0] denb_ff;
   logic        nega_ff, negb_ff;

   assign dena_w  = {full_ff, 2'b00} + {2'b00, full_ff, 1'b0};
   assign denb_w  = {full_ff, 1'b0};
   assign nsa_w   = (52'(na3_ff) <<< 17) + 52'(dena_w >> 1);
   assign nsb_w   = (51'(nb2_ff) <<< 1) + 51'(full_ff);
   assign mag_a_w = nsa_w[51] ? -nsa_w : nsa_w;
   assign mag_b_w = nsb_w[50] ? -nsb_w : nsb_w;

   always_ff @(posedge clock) begin
      numa_ff <= nsa_w[51] ? $unsigned(mag_a_w) + 52'(dena_w) - 52'd1 : $unsigned(mag_a_w);
      numb_ff <= nsb_w[50] ? $unsigned(mag_b_w) + 51'(denb_w) - 51'd1 : $unsigned(mag_b_w);
      dena_ff <= dena_w;
      denb_ff <= denb_w;
      nega_ff <= nsa_w[51];
      negb_ff <= nsb_w[50];
      da4_ff  <= da3_ff;
      db4_ff  <= db3_ff;
      dc4_ff  <= dc3_ff;
      csa4_ff <= csa3_ff;
      sna4_ff <= sna3_ff;
   end

   // Voltage dividers.
   localparam int ASW = 1 + 48 + 32;
   logic           avd_out, bvd_out;
   logic [33:0]    qa_out, qb_out;
   logic [ASW-1:0] aside_out;
   logic           bside_out;

   svpwm_div #(.NW(52), .DW(19), .QW(34), .SW(ASW)) u_alpha_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (va4_ff),
      .in_num   (numa_ff),
      .in_den   (dena_ff),
      .in_side  ({nega_ff, da4_ff, db4_ff, dc4_ff, csa4_ff, sna4_ff}),
      .out_valid(avd_out),
      .out_quo  (qa_out),
      .out_side (aside_out)
   );

   svpwm_div #(.NW(51), .DW(17), .QW(34), .SW(1)) u_beta_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (va4_ff),
      .in_num   (numb_ff),
      .in_den   (denb_ff),
      .in_side  (negb_ff),
      .out_valid(bvd_out),
      .out_quo  (qb_out),
      .out_side (bside_out)
   );

   logic               q_nega;
   logic [15:0]        q_da, q_db, q_dc;
   logic signed [15:0] q_cs, q_sn;
   logic signed [34:0] va_w, vb_w;
   logic signed [35:0] ra_w, rb_w;

   assign {q_nega, q_da, q_db, q_dc, q_cs, q_sn} = aside_out;
   assign va_w = q_nega ? -$signed({1'b0, qa_out}) : $signed({1'b0, qa_out});
   assign vb_w = bside_out ? -$signed({1'b0, qb_out}) : $signed({1'b0, qb_out});
   assign ra_w = 36'(va_w) + 36'sd32768;
   assign rb_w = 36'(vb_w) + 36'sd32768;

   // O1: alpha/beta outputs and rotor products.
   logic signed [50:0] cva_ff, svb_ff, cvb_ff, sva_ff;
   logic [15:0] oa_ff, ob_ff, od0_ff, od1_ff, od2_ff;
   logic        vo1_ff;

   always_ff @(posedge clock) begin
      cva_ff <= 51'(q_cs) * 51'(va_w);
      svb_ff <= 51'(q_sn) * 51'(vb_w);
      cvb_ff <= 51'(q_cs) * 51'(vb_w);
      sva_ff <= 51'(q_sn) * 51'(va_w);
      oa_ff  <= sat16({ra_w[35], ra_w[35:16]});
      ob_ff  <= sat16({rb_w[35], rb_w[35:16]});
      od0_ff <= q_da;
      od1_ff <= q_db;
      od2_ff <= q_dc;
   end

   // O2: d/q rounding and result registers.
   logic signed [51:0] dsum_w, qsum_w;
   logic               zero_full;

   assign dsum_w    = 52'(cva_ff) + 52'(svb_ff) + 52'sh4000_0000;
   assign qsum_w    = 52'(cvb_ff) - 52'(sva_ff) + 52'sh4000_0000;
   assign zero_full = full_ff == 16'd0;

   always_ff @(posedge clock) begin
      rsp_duty_a             <= od0_ff;
      rsp_duty_b             <= od1_ff;
      rsp_duty_c             <= od2_ff;
      rsp_applied_alpha      <= zero_full ? 16'sd0 : $signed(oa_ff);
      rsp_applied_beta       <= zero_full ? 16'sd0 : $signed(ob_ff);
      rsp_applied_direct     <= zero_full ? 16'sd0 : $signed(sat16(dsum_w[51:31]));
      rsp_applied_quadrature <= zero_full ? 16'sd0 : $signed(sat16(qsum_w[51:31]));
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         vm1_ff     <= 1'b0;
         vm2_ff     <= 1'b0;
         vm3_ff     <= 1'b0;
         va1_ff     <= 1'b0;
         va2_ff     <= 1'b0;
         va3_ff     <= 1'b0;
         va4_ff     <= 1'b0;
         vo1_ff     <= 1'b0;
         rsp_strobe <= 1'b0;
      end else begin
         v1_ff      <= start & ~busy;
         v2_ff      <= v1_ff;
         v3_ff      <= v2_ff;
         vm1_ff     <= rv_out;
         vm2_ff     <= vm1_ff;
         vm3_ff     <= vm2_ff;
         va1_ff     <= vm3_ff;
         va2_ff     <= va1_ff;
         va3_ff     <= va2_ff;
         va4_ff     <= va3_ff;
         vo1_ff     <= avd_out & bvd_out;
         rsp_strobe <= vo1_ff;
      end
   end

`ifndef SYNTH
   a_phase_sum_zero: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> (p0_ff + p1_ff + p2_ff) == 35'sd0)
      else $error("phase projection does not sum to zero");

   a_div_aligned: assert property (@(posedge clock) disable iff (reset)
      avd_out == bvd_out)
      else $error("voltage dividers out of step");

   a_duty_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_duty_a <= full_ff && rsp_duty_b <= full_ff && rsp_duty_c <= full_ff)
      else $error("duty above full count");

   a_zero_period: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && full_ff == 16'd0 |-> rsp_applied_alpha == 16'sd0
         && rsp_applied_direct == 16'sd0 && rsp_applied_quadrature == 16'sd0)
      else $error("applied voltage nonzero with zero period");
`endif

endmodule

// ===== tb/sv/tb_minmax_space_vector_pwm.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the min/max space-vector PWM modulator.
// Needs svpwm_pkg and minmax_space_vector_pwm; predicts every update in a scoreboard class.
module tb_minmax_space_vector_pwm;
   import svpwm_pkg::*;

   typedef struct packed {
      logic [15:0]        duty_a;
      logic [15:0]        duty_b;
      logic [15:0]        duty_c;
      logic signed [15:0] v_alpha;
      logic signed [15:0] v_beta;
      logic signed [15:0] v_direct;
      logic signed [15:0] v_quad;
   } pwm_update_type;

   class svpwm_scoreboard;
      logic [15:0] full_count;
      logic [15:0] min_pulse;
      logic [15:0] clean_zone;
      logic [16:0] span_limit;
      pwm_update_type pending_updates[$];
      int          errors;

      function new();
         full_count = FULL_COUNT_RESET;
         min_pulse  = MIN_PULSE_RESET;
         clean_zone = CLEAN_ZONE_RESET;
         span_limit = SPAN_LIMIT_RESET;
         errors     = 0;
      endfunction

      function longint fdiv(longint n, longint d);
         longint q;
         q = n / d;
         if ((n % d) != 0 && n < 0) q = q - 1;
         return q;
      endfunction

      function logic [15:0] clamp16(longint v);
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         return v[15:0];
      endfunction

      function void note_request(logic signed [16:0] alpha, logic signed [16:0] beta,
                                 logic signed [15:0] cs, logic signed [15:0] sn,
                                 logic [15:0] bus);
         longint     ph[3];
         longint     cnt[3];
         longint     lo, hi, span, lim, ratio, full, minp, guard, x, va, vb, two31;
         pwm_update_type u;
         full  = full_count;
         minp  = min_pulse;
         guard = full - (minp + longint'(clean_zone));
         lim   = longint'(span_limit) * 65536;
         ph[0] = longint'(alpha) * 65536;
         ph[1] = -longint'(alpha) * 32768 + 56756 * longint'(beta);
         ph[2] = -longint'(alpha) * 32768 - 56756 * longint'(beta);
         lo = ph[0];
         hi = ph[0];
         for (int i = 1; i < 3; i++) begin
            if (ph[i] < lo) lo = ph[i];
            if (ph[i] > hi) hi = ph[i];
         end
         span = hi - lo;
         for (int i = 0; i < 3; i++) ph[i] = ph[i] - lo;
         if (span > lim) begin
            ratio = (lim * (longint'(1) << 24)) / span;
            for (int i = 0; i < 3; i++) ph[i] = (ph[i] * ratio) / (longint'(1) << 24);
         end
         for (int i = 0; i < 3; i++) begin
            x = (full * ph[i] + (longint'(1) << 30)) / (longint'(1) << 31);
            if (x < minp) cnt[i] = 0;
            else if (x > guard) cnt[i] = full;
            else cnt[i] = x;
         end
         u.duty_a = cnt[0][15:0];
         u.duty_b = cnt[1][15:0];
         u.duty_c = cnt[2][15:0];
         if (full == 0) begin
            u.v_alpha  = '0;
            u.v_beta   = '0;
            u.v_direct = '0;
            u.v_quad   = '0;
         end else begin
            two31 = longint'(1) << 31;
            va = fdiv(2 * ((2 * cnt[0] - cnt[1] - cnt[2]) * longint'(bus) * 65536)
                      + 3 * full, 6 * full);
            vb = fdiv(2 * ((cnt[1] - cnt[2]) * longint'(bus) * 37837) + full, 2 * full);
            u.v_alpha  = clamp16(fdiv(va + 32768, 65536));
            u.v_beta   = clamp16(fdiv(vb + 32768, 65536));
            u.v_direct = clamp16(fdiv(longint'(cs) * va + longint'(sn) * vb
                                      + (two31 >> 1), two31));
            u.v_quad   = clamp16(fdiv(longint'(cs) * vb - longint'(sn) * va
                                      + (two31 >> 1), two31));
         end
         pending_updates.push_back(u);
      endfunction

      function void check_update(pwm_update_type got);
         pwm_update_type exp_u;
         if (pending_updates.size() == 0) begin
            $display("%0t: unexpected update %h", $realtime, got);
            errors++;
            return;
         end
         exp_u = pending_updates.pop_front();
         if (got.duty_a !== exp_u.duty_a) begin
            $display("%0t: duty_a exp %0d got %0d", $realtime, exp_u.duty_a, got.duty_a);
            errors++;
         end
         if (got.duty_b !== exp_u.duty_b) begin
            $display("%0t: duty_b exp %0d got %0d", $realtime, exp_u.duty_b, got.duty_b);
            errors++;
         end
         if (got.duty_c !== exp_u.duty_c) begin
            $display("%0t: duty_c exp %0d got %0d", $realtime, exp_u.duty_c, got.duty_c);
            errors++;
         end
         if (got.v_alpha !== exp_u.v_alpha) begin
            $display("%0t: applied_alpha exp %0d got %0d", $realtime, exp_u.v_alpha,
                     got.v_alpha);
            errors++;
         end
         if (got.v_beta !== exp_u.v_beta) begin
            $display("%0t: applied_beta exp %0d got %0d", $realtime, exp_u.v_beta,
                     got.v_beta);
            errors++;
         end
         if (got.v_direct !== exp_u.v_direct) begin
            $display("%0t: applied_direct exp %0d got %0d", $realtime, exp_u.v_direct,
                     got.v_direct);
            errors++;
         end
         if (got.v_quad !== exp_u.v_quad) begin
            $display("%0t: applied_quadrature exp %0d got %0d", $realtime, exp_u.v_quad,
                     got.v_quad);
            errors++;
         end
      endfunction
   endclass

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 100;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [16:0] req_volt_alpha = '0;
   logic signed [16:0] req_volt_beta = '0;
   logic signed [15:0] req_rotor_cos = '0;
   logic signed [15:0] req_rotor_sin = '0;
   logic [15:0]        req_bus_voltage = '0;
   logic               rsp_strobe;
   logic [15:0]        rsp_duty_a, rsp_duty_b, rsp_duty_c;
   logic signed [15:0] rsp_applied_alpha, rsp_applied_beta;
   logic signed [15:0] rsp_applied_direct, rsp_applied_quadrature;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [3:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   svpwm_scoreboard sb = new();
   int              cycle_count = 0;
   bit              busy_gaps;

   minmax_space_vector_pwm dut (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** minmax_space_vector_pwm: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_update({rsp_duty_a, rsp_duty_b, rsp_duty_c, rsp_applied_alpha,
                          rsp_applied_beta, rsp_applied_direct, rsp_applied_quadrature});
   end

   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_FULL_COUNT: sb.full_count = value[15:0];
         REG_MIN_PULSE:  sb.min_pulse  = value[15:0];
         REG_CLEAN_ZONE: sb.clean_zone = value[15:0];
         default:        sb.span_limit = value[16:0];
      endcase
   endtask

   task automatic send_word(logic signed [16:0] alpha, logic signed [16:0] beta,
                            logic signed [15:0] cs, logic signed [15:0] sn,
                            logic [15:0] bus);
      int  gap;
      bit  taken;
      gap = busy_gaps ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start           <= 1'b1;
      req_volt_alpha  <= alpha;
      req_volt_beta   <= beta;
      req_rotor_cos   <= cs;
      req_rotor_sin   <= sn;
      req_bus_voltage <= bus;
      taken = 1'b0;
      while (!taken) begin
         #0.1;
         taken = !busy;
         @(posedge clock);
         @(negedge clock);
      end
      sb.note_request(alpha, beta, cs, sn, bus);
   endtask

   task automatic quiesce();
      start <= 1'b0;
      @(negedge clock);
      while (sb.pending_updates.size() > 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic send_random(int count);
      logic signed [16:0] alpha, beta;
      logic [15:0]        bus;
      for (int n = 0; n < count; n++) begin
         if (n % 50 == 0) busy_gaps = $urandom_range(0, 2) != 0;
         if ($urandom_range(0, 3) == 0) begin
            alpha = 17'($urandom);
            beta  = 17'($urandom);
         end else begin
            alpha = 17'($urandom_range(0, 80000) - 40000);
            beta  = 17'($urandom_range(0, 80000) - 40000);
         end
         case ($urandom_range(0, 9))
            0:       bus = 16'h0000;
            1:       bus = 16'hFFFF;
            default: bus = 16'($urandom);
         endcase
         send_word(alpha, beta, 16'($urandom), 16'($urandom), bus);
      end
   endtask

   initial begin
      logic signed [16:0] edge_v[5];
      edge_v = '{17'sh10000, 17'sh0FFFF, 17'sd0, 17'sd1, -17'sd1};
      busy_gaps = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 5; i++)
         for (int j = 0; j < 5; j++)
            if (i + j < 8)
               send_word(edge_v[i], edge_v[j], (i % 2) ? 16'sh8000 : 16'sh7FFF,
                         (j % 2) ? 16'sh7FFF : 16'sh8000, (i + j) % 3 ? 16'hFFFF : 16'h0100);
      send_random(150);
      quiesce();

      write_reg(REG_FULL_COUNT, 32'd65535);
      write_reg(REG_MIN_PULSE, 32'd0);
      write_reg(REG_CLEAN_ZONE, 32'd0);
      write_reg(REG_SPAN_LIMIT, 32'd65536);
      send_random(150);
      quiesce();

      write_reg(REG_FULL_COUNT, 32'd1);
      write_reg(REG_SPAN_LIMIT, 32'd0);
      send_random(120);
      quiesce();

      write_reg(REG_FULL_COUNT, 32'd0);
      write_reg(REG_SPAN_LIMIT, 32'd20000);
      send_random(100);
      quiesce();

      write_reg(REG_FULL_COUNT, 32'd2000);
      write_reg(REG_MIN_PULSE, 32'd65535);
      write_reg(REG_CLEAN_ZONE, 32'd65535);
      send_random(100);
      quiesce();

      write_reg(REG_FULL_COUNT, 32'd5000);
      write_reg(REG_MIN_PULSE, 32'd100);
      write_reg(REG_CLEAN_ZONE, 32'd4000);
      write_reg(REG_SPAN_LIMIT, 32'd65535);
      send_random(150);
      quiesce();

      for (int k = 0; k < 3; k++) begin
         write_reg(REG_FULL_COUNT, $urandom_range(1, 65535));
         write_reg(REG_MIN_PULSE, $urandom_range(0, 300));
         write_reg(REG_CLEAN_ZONE, $urandom_range(0, 300));
         write_reg(REG_SPAN_LIMIT, $urandom_range(0, 65536));
         send_random(150);
         quiesce();
      end

      if (sb.errors == 0 && sb.pending_updates.size() == 0) begin
         $display("** minmax_space_vector_pwm: PASSED **");
      end else begin
         $display("** minmax_space_vector_pwm: FAILED **");
      end
      $finish;
   end

endmodule
